// ===== rtl/core/lnbs_pkg.sv =====
`default_nettype none

package lnbs_pkg;

  // Field and register widths fixed by the item and register formats.
  localparam int unsigned SMOOTH_W   = 8;
  localparam int unsigned ROWS_USE_W = 7;
  localparam int unsigned CLS_USE_W  = 5;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned PROB_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // The divider produces one quotient bit per step.
  localparam int unsigned DIV_STEPS  = PROB_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // Register reset values.
  localparam logic [SMOOTH_W-1:0]   SMOOTH_RESET  = 8'd1;
  localparam logic [ROWS_USE_W-1:0] ROWS_RESET    = 7'd40;
  localparam logic [CLS_USE_W-1:0]  CLASSES_RESET = 5'd11;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTHING = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROWS      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLASSES   = 2'd2;

  // Item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_ZERO_DEN = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // write one zero entry of the clearing pass
    logic load;      // capture the input transaction and read the table
    logic lookup;    // apply a write, or form the smoothed terms of a query
    logic mul;       // form numerator and denominator products
    logic check;     // test for zero denominator and saturation
    logic div_step;  // one restoring division step
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic idx_ok;
    logic is_query;
    logic den_zero;
    logic saturate;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/lnbs_datapath.sv =====
`default_nettype none

module lnbs_datapath #(
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_CLASSES = 16,
  localparam int unsigned ROW_W      = $clog2(MAX_ROWS),
  localparam int unsigned CLS_W      = $clog2(MAX_CLASSES)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire lnbs_pkg::cmd_t                    cmd_i,
  output      lnbs_pkg::stat_t                   stat_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [lnbs_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [lnbs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              kind_i,
  input  wire logic [ROW_W-1:0]                  row_i,
  input  wire logic [CLS_W-1:0]                  cls_i,
  input  wire logic [lnbs_pkg::COUNT_W-1:0]      count_i,
  output      lnbs_pkg::status_e                 status_o,
  output      logic [lnbs_pkg::PROB_W-1:0]       prob_o
);

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_CLASSES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CW     = lnbs_pkg::COUNT_W;
  // Column sum and grand total widths hold the largest possible sums.
  localparam int unsigned COL_W  = $clog2(MAX_ROWS * 255 + 1);
  localparam int unsigned TOT_W  = $clog2(DEPTH * 255 + 1);
  localparam int unsigned A1_W   = COL_W + 1;
  localparam int unsigned A2_W   = CW + 1;
  localparam int unsigned KC_W   = lnbs_pkg::SMOOTH_W + lnbs_pkg::CLS_USE_W;
  localparam int unsigned KR_W   = lnbs_pkg::SMOOTH_W + lnbs_pkg::ROWS_USE_W;
  localparam int unsigned D1_W   = ((TOT_W > KC_W) ? TOT_W : KC_W) + 1;
  localparam int unsigned D2_W   = ((COL_W > KR_W) ? COL_W : KR_W) + 1;
  localparam int unsigned NUM_W  = A1_W + A2_W;
  localparam int unsigned DEN_W  = D1_W + D2_W;
  localparam int unsigned RC_W   = (ROW_W > lnbs_pkg::ROWS_USE_W) ? ROW_W
                                                                  : lnbs_pkg::ROWS_USE_W;
  localparam int unsigned CC_W   = (CLS_W > lnbs_pkg::CLS_USE_W) ? CLS_W
                                                                 : lnbs_pkg::CLS_USE_W;
  localparam int unsigned PW     = lnbs_pkg::PROB_W;

  // Configuration registers.
  logic [lnbs_pkg::SMOOTH_W-1:0]   smooth_q;
  logic [lnbs_pkg::ROWS_USE_W-1:0] rows_use_q;
  logic [lnbs_pkg::CLS_USE_W-1:0]  cls_use_q;

  // Captured transaction.
  logic              kind_q;
  logic [CLS_W-1:0]  cls_q;
  logic [CW-1:0]     val_q;
  logic [ADDR_W-1:0] addr_q;
  logic              idx_ok_q;
  logic [CW-1:0]     rd_q;

  // Count table and running sums.
  logic [CW-1:0]     mem_q [DEPTH];
  logic [COL_W-1:0]  col_sum_q [MAX_CLASSES];
  logic [TOT_W-1:0]  total_q;
  logic [ADDR_W-1:0] clr_addr_q;

  // Arithmetic pipeline and divider.
  logic [A1_W-1:0]   a1_q;
  logic [A2_W-1:0]   a2_q;
  logic [D1_W-1:0]   d1_q;
  logic [D2_W-1:0]   d2_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [PW-1:0]     quo_q;
  lnbs_pkg::status_e res_status_q;
  lnbs_pkg::status_e out_status_q;
  logic [PW-1:0]     out_prob_q;

  logic              idx_ok_d;
  logic [ADDR_W-1:0] addr_d;
  logic [COL_W-1:0]  nj;
  logic              wr_item;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CW-1:0]     mem_wdata;
  logic [KC_W-1:0]   kc;
  logic [KR_W-1:0]   kr;
  logic [NUM_W-1:0]  num_d;
  logic [DEN_W-1:0]  den_d;
  logic [DEN_W:0]    rem_shift;
  logic [DEN_W:0]    rem_diff;
  logic              rem_ge;
  logic              den_zero;
  logic              saturate;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q   <= lnbs_pkg::SMOOTH_RESET;
      rows_use_q <= lnbs_pkg::ROWS_RESET;
      cls_use_q  <= lnbs_pkg::CLASSES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lnbs_pkg::CFG_SMOOTHING: smooth_q   <= cfg_wdata_i;
        lnbs_pkg::CFG_ROWS:      rows_use_q <= lnbs_pkg::ROWS_USE_W'(cfg_wdata_i);
        lnbs_pkg::CFG_CLASSES:   cls_use_q  <= lnbs_pkg::CLS_USE_W'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Index check and table address of the incoming transaction.
  always_comb begin
    idx_ok_d = (RC_W'(row_i) < RC_W'(rows_use_q)) &&
               ((ROW_W + 1)'(row_i) < (ROW_W + 1)'(MAX_ROWS)) &&
               (CC_W'(cls_i) < CC_W'(cls_use_q)) &&
               ((CLS_W + 1)'(cls_i) < (CLS_W + 1)'(MAX_CLASSES));
    addr_d   = ADDR_W'(row_i) * ADDR_W'(MAX_CLASSES) + ADDR_W'(cls_i);
  end

  assign nj      = col_sum_q[cls_q];
  assign wr_item = idx_ok_q && (kind_q == lnbs_pkg::KIND_WRITE);

  // Table write port is shared by the clearing pass and count writes.
  assign mem_we    = cmd_i.clear || (cmd_i.lookup && wr_item);
  assign mem_waddr = cmd_i.clear ? clr_addr_q : addr_q;
  assign mem_wdata = cmd_i.clear ? '0 : val_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.load) begin
      rd_q <= mem_q[addr_d];
    end
  end

  // Clearing pass address after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Running column sums and grand total follow every accepted count write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
        col_sum_q[i] <= '0;
      end
      total_q <= '0;
    end else if (cmd_i.lookup && wr_item) begin
      col_sum_q[cls_q] <= nj - COL_W'(rd_q) + COL_W'(val_q);
      total_q          <= total_q - TOT_W'(rd_q) + TOT_W'(val_q);
    end
  end

  // Smoothed terms, products and the restoring divider.
  assign kc        = KC_W'(smooth_q) * KC_W'(cls_use_q);
  assign kr        = KR_W'(smooth_q) * KR_W'(rows_use_q);
  assign num_d     = a1_q * a2_q;
  assign den_d     = d1_q * d2_q;
  assign den_zero  = (den_q == '0);
  assign saturate  = (DEN_W'(num_q) >= den_q);
  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, den_q});
  assign rem_diff  = rem_shift - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      cls_q    <= cls_i;
      val_q    <= count_i;
      addr_q   <= addr_d;
      idx_ok_q <= idx_ok_d;
    end
    if (cmd_i.lookup) begin
      a1_q         <= A1_W'(nj) + A1_W'(smooth_q);
      a2_q         <= A2_W'(rd_q) + A2_W'(smooth_q);
      d1_q         <= D1_W'(total_q) + D1_W'(kc);
      d2_q         <= D2_W'(nj) + D2_W'(kr);
      res_status_q <= idx_ok_q ? lnbs_pkg::STATUS_OK : lnbs_pkg::STATUS_RANGE;
      quo_q        <= '0;
    end
    if (cmd_i.mul) begin
      num_q <= num_d;
      den_q <= den_d;
    end
    if (cmd_i.check) begin
      if (den_zero) begin
        res_status_q <= lnbs_pkg::STATUS_ZERO_DEN;
      end else if (saturate) begin
        quo_q <= '1;
      end else begin
        rem_q <= DEN_W'(num_q);
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? DEN_W'(rem_diff) : DEN_W'(rem_shift);
      quo_q <= {quo_q[PW-2:0], rem_ge};
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_prob_q   <= quo_q;
    end
  end

  assign status_o = out_status_q;
  assign prob_o   = out_prob_q;

  assign stat_o.clear_last = (clr_addr_q == ADDR_W'(DEPTH - 1));
  assign stat_o.idx_ok     = idx_ok_q;
  assign stat_o.is_query   = (kind_q == lnbs_pkg::KIND_QUERY);
  assign stat_o.den_zero   = den_zero;
  assign stat_o.saturate   = saturate;

endmodule

`default_nettype wire

// ===== rtl/core/lnbs_ctrl.sv =====
`default_nettype none

module lnbs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  output      logic            s_ready_o,
  input  wire logic            m_ready_i,
  output      logic            m_valid_o,
  output      lnbs_pkg::cmd_t  cmd_o,
  input  wire lnbs_pkg::stat_t stat_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam logic [lnbs_pkg::DIV_CNT_W-1:0] DIV_LAST =
    lnbs_pkg::DIV_CNT_W'(lnbs_pkg::DIV_STEPS - 1);

  state_e                           state_q;
  logic [lnbs_pkg::DIV_CNT_W-1:0]   div_cnt_q;
  logic                             m_valid_q;

  // Commands decoded from the current state.
  always_comb begin
    cmd_o          = '0;
    cmd_o.clear    = (state_q == ST_CLEAR);
    cmd_o.load     = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.lookup   = (state_q == ST_LOOKUP);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.check    = (state_q == ST_CHECK);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.out_load = (state_q == ST_DONE) && (!m_valid_q || m_ready_i);
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

  // State, division step count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      div_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (stat_i.clear_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_valid_i) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state_q <= (stat_i.idx_ok && stat_i.is_query) ? ST_MUL : ST_DONE;
        end
        ST_MUL: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          div_cnt_q <= '0;
          state_q   <= (stat_i.den_zero || stat_i.saturate) ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == DIV_LAST) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd_o.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An accepted transaction always goes on to the table lookup.
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && s_valid_i) |=> (state_q == ST_LOOKUP))
    else $error("accepted transaction did not reach lookup");

  // The division step count advances by one each step.
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_cnt_q != DIV_LAST) |=>
      (state_q == ST_DIV && div_cnt_q == $past(div_cnt_q) + 1'b1))
    else $error("division step count skipped");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!m_valid_q || m_ready_i))
    else $error("output register overwritten");

  // Zero denominator and saturation skip the divider.
  a_early_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && (stat_i.den_zero || stat_i.saturate)) |=>
      (state_q == ST_DONE))
    else $error("early result did not bypass the divider");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/laplace_naive_bayes_score.sv =====
`default_nettype none

// Channel  Direction  Carries
// s_axis   in         tuser: kind; tdata: row_index, class_index, count_value
// m_axis   out        tuser: status; tdata: probability
// cfg      in         write enable, register index, write data
//
// A query passes from acceptance through these steps until the block is
// ready again: the smoothed sums, the products, a check, 32 steps of the
// one-bit-per-cycle restoring divider, and the output load. A write or an
// out-of-range item goes from the lookup straight to the output load; a zero
// denominator or a saturated result goes from the check to the output load.
// After reset the count table is cleared, one entry per cycle, for all
// MAX_ROWS*MAX_CLASSES entries (1024 by default) before the first transaction.
// A finished result waits in the output register; the block then takes the
// next item but holds its own result until the register is free.

module laplace_naive_bayes_score #(
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_CLASSES = 16,
  localparam int unsigned ROW_W      = $clog2(MAX_ROWS),
  localparam int unsigned CLS_W      = $clog2(MAX_CLASSES),
  localparam int unsigned IN_BITS    = ROW_W + CLS_W + lnbs_pkg::COUNT_W,
  localparam int unsigned IN_W       = ((IN_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // row_index, class_index, count_value, zero fill
  input  wire logic [IN_W-1:0]                   s_axis_tdata,
  // kind
  input  wire logic                              s_axis_tuser,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // probability
  output      logic [lnbs_pkg::PROB_W-1:0]       m_axis_tdata,
  // status
  output      logic [lnbs_pkg::STATUS_W-1:0]     m_axis_tuser,
  input  wire logic                              cfg_we_i,
  input  wire logic [lnbs_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [lnbs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  lnbs_pkg::cmd_t    cmd;
  lnbs_pkg::stat_t   stat;
  lnbs_pkg::status_e status;

  // Sequencing of each transaction.
  lnbs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  // Table, sums and arithmetic.
  lnbs_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (s_axis_tuser),
    .row_i       (s_axis_tdata[ROW_W-1:0]),
    .cls_i       (s_axis_tdata[ROW_W+CLS_W-1:ROW_W]),
    .count_i     (s_axis_tdata[IN_BITS-1:ROW_W+CLS_W]),
    .status_o    (status),
    .prob_o      (m_axis_tdata)
  );

  assign m_axis_tuser = status;

endmodule

`default_nettype wire

// ===== test/tb_laplace_naive_bayes_score.sv =====
`default_nettype none

module tb_laplace_naive_bayes_score;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IN_W       = 24;
  localparam int unsigned TABLE_ROWS = 64;
  localparam int unsigned TABLE_COLS = 16;

  // One expected result: status code and Q0.32 score.
  typedef struct {
    lnbs_pkg::status_e         status;
    bit [lnbs_pkg::PROB_W-1:0] probability;
  } score_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  wire logic             s_axis_tready;
  // row_index, class_index, count_value, zero fill
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  // kind
  logic                  s_axis_tuser  = 1'b0;
  wire logic             m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  // probability
  wire logic [lnbs_pkg::PROB_W-1:0]   m_axis_tdata;
  // status
  wire logic [lnbs_pkg::STATUS_W-1:0] m_axis_tuser;
  logic                            cfg_we_i      = 1'b0;
  logic [lnbs_pkg::CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [lnbs_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  // Shadow copy of the block's state and registers.
  bit [lnbs_pkg::COUNT_W-1:0]    count_tab [TABLE_ROWS*TABLE_COLS];
  bit [13:0]                     class_sums [TABLE_COLS];
  bit [17:0]                     table_total   = '0;
  bit [lnbs_pkg::SMOOTH_W-1:0]   smooth_k      = lnbs_pkg::SMOOTH_RESET;
  bit [lnbs_pkg::ROWS_USE_W-1:0] rows_r        = lnbs_pkg::ROWS_RESET;
  bit [lnbs_pkg::CLS_USE_W-1:0]  classes_c     = lnbs_pkg::CLASSES_RESET;

  score_t      pending_scores [$];
  int unsigned error_count = 0;
  bit          no_idle     = 1'b0;
  int unsigned sink_hold   = 0;

  laplace_naive_bayes_score u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit, well above the slowest legal run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Apply one item to the shadow state and return the result it must produce.
  function automatic score_t score_item(input logic kind, input bit [5:0] row,
                                        input bit [3:0] cls, input bit [7:0] cnt);
    score_t    res;
    bit [9:0]  slot;
    bit [63:0] k, nj, f, num, den, quo;
    res.status      = lnbs_pkg::STATUS_OK;
    res.probability = '0;
    slot = {row, cls};
    // The field widths already keep the indexes below the table sizes.
    if (row >= rows_r || cls >= classes_c) begin
      res.status = lnbs_pkg::STATUS_RANGE;
    end else if (kind == lnbs_pkg::KIND_WRITE) begin
      class_sums[cls] = class_sums[cls] - count_tab[slot] + cnt;
      table_total     = table_total - count_tab[slot] + cnt;
      count_tab[slot] = cnt;
    end else begin
      k   = 64'(smooth_k);
      nj  = 64'(class_sums[cls]);
      f   = 64'(count_tab[slot]);
      num = (nj + k) * (f + k);
      den = (64'(table_total) + k * 64'(classes_c)) * (nj + k * 64'(rows_r));
      if (den == 0) begin
        res.status = lnbs_pkg::STATUS_ZERO_DEN;
      end else begin
        quo = (num << 32) / den;
        res.probability = (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
      end
    end
    return res;
  endfunction

  // Send one item after a random gap and record its expected result.
  task automatic send_item(input logic kind, input bit [5:0] row, input bit [3:0] cls,
                           input bit [7:0] cnt);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'b0, cnt, cls, row};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_scores.push_back(score_item(kind, row, cls, cnt));
  endtask

  // Hold off the sender until every expected result has arrived.
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_scores.size() != 0);
  endtask

  // Write all three registers while the block is idle.
  task automatic program_registers(input bit [7:0] k, input bit [7:0] r, input bit [7:0] c);
    wait_results();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= lnbs_pkg::CFG_SMOOTHING;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_addr_i  <= lnbs_pkg::CFG_ROWS;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_addr_i  <= lnbs_pkg::CFG_CLASSES;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    smooth_k  = k;
    rows_r    = r[lnbs_pkg::ROWS_USE_W-1:0];
    classes_c = c[lnbs_pkg::CLS_USE_W-1:0];
  endtask

  // Queries on the empty table with the reset register values, and an out-of-range write.
  task automatic test_reset_defaults();
    send_item(lnbs_pkg::KIND_QUERY, 6'd0, 4'd0, 8'd0);
    send_item(lnbs_pkg::KIND_QUERY, 6'd39, 4'd10, 8'd255);
    send_item(lnbs_pkg::KIND_QUERY, 6'd40, 4'd0, 8'd0);
    send_item(lnbs_pkg::KIND_QUERY, 6'd0, 4'd11, 8'd0);
    send_item(lnbs_pkg::KIND_WRITE, 6'd63, 4'd15, 8'd255);
  endtask

  // A single entry with unit sizes gives a quotient of one, which saturates.
  task automatic test_saturation();
    program_registers(8'd1, 8'd1, 8'd1);
    send_item(lnbs_pkg::KIND_WRITE, 6'd0, 4'd0, 8'd200);
    send_item(lnbs_pkg::KIND_QUERY, 6'd0, 4'd0, 8'd0);
    send_item(lnbs_pkg::KIND_WRITE, 6'd0, 4'd0, 8'd0);
    send_item(lnbs_pkg::KIND_QUERY, 6'd0, 4'd0, 8'd77);
  endtask

  // Largest indexes and counts, then sizes reduced below a stored entry.
  task automatic test_extremes_and_shrink();
    program_registers(8'd255, 8'd64, 8'd16);
    send_item(lnbs_pkg::KIND_WRITE, 6'd63, 4'd15, 8'd255);
    send_item(lnbs_pkg::KIND_WRITE, 6'd50, 4'd3, 8'd100);
    send_item(lnbs_pkg::KIND_QUERY, 6'd63, 4'd15, 8'd0);
    program_registers(8'd1, 8'd40, 8'd16);
    send_item(lnbs_pkg::KIND_QUERY, 6'd0, 4'd3, 8'd0);
    send_item(lnbs_pkg::KIND_QUERY, 6'd50, 4'd3, 8'd0);
    send_item(lnbs_pkg::KIND_WRITE, 6'd50, 4'd3, 8'd1);
  endtask

  // Zero smoothing: an empty column has a zero denominator.
  task automatic test_zero_smoothing();
    program_registers(8'd0, 8'd64, 8'd16);
    send_item(lnbs_pkg::KIND_QUERY, 6'd0, 4'd7, 8'd0);
    send_item(lnbs_pkg::KIND_QUERY, 6'd63, 4'd15, 8'd0);
  endtask

  // Size registers at zero reject everything; oversized ones only scale.
  task automatic test_register_limits();
    program_registers(8'd2, 8'd0, 8'd16);
    send_item(lnbs_pkg::KIND_QUERY, 6'd0, 4'd0, 8'd0);
    program_registers(8'd2, 8'd64, 8'd0);
    send_item(lnbs_pkg::KIND_WRITE, 6'd0, 4'd0, 8'd9);
    program_registers(8'd255, 8'd127, 8'd31);
    send_item(lnbs_pkg::KIND_QUERY, 6'd63, 4'd15, 8'd0);
    send_item(lnbs_pkg::KIND_WRITE, 6'd42, 4'd10, 8'd170);
  endtask

  // Random items over several register settings, mostly inside the sizes in use.
  task automatic test_random_traffic();
    bit [7:0]    k, r, c;
    bit [5:0]    row;
    bit [3:0]    cls;
    bit [7:0]    cnt;
    logic        kind;
    int unsigned row_lim, cls_lim;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin k = 8'd1;   r = 8'd64;  c = 8'd16; end
        1: begin k = 8'd0;   r = 8'd64;  c = 8'd16; end
        2: begin k = 8'd255; r = 8'd64;  c = 8'd16; end
        4: begin k = 8'd7;   r = 8'd1;   c = 8'd1;  end
        5: begin k = 8'd3;   r = 8'd127; c = 8'd31; end
        7: begin k = 8'd1;   r = 8'd64;  c = 8'd16; end
        default: begin
          k = 8'($urandom_range(0, 255));
          r = 8'($urandom_range(1, 64));
          c = 8'($urandom_range(1, 16));
        end
      endcase
      program_registers(k, r, c);
      no_idle = (phase == 7);
      row_lim = (rows_r > TABLE_ROWS) ? TABLE_ROWS : rows_r;
      cls_lim = (classes_c > TABLE_COLS) ? TABLE_COLS : classes_c;
      for (int n = 0; n < 250; n++) begin
        if (n == 125) wait_results();
        kind = 1'($urandom_range(0, 1));
        if (row_lim != 0 && $urandom_range(0, 9) != 0) begin
          row = 6'($urandom_range(0, row_lim - 1));
        end else begin
          row = 6'($urandom_range(0, 63));
        end
        if (cls_lim != 0 && $urandom_range(0, 9) != 0) begin
          cls = 4'($urandom_range(0, cls_lim - 1));
        end else begin
          cls = 4'($urandom_range(0, 15));
        end
        case ($urandom_range(0, 7))
          0: cnt = 8'd0;
          1: cnt = 8'd255;
          default: cnt = 8'($urandom_range(0, 255));
        endcase
        send_item(kind, row, cls, cnt);
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: check each transaction, then stall at random unless no_idle is set.
  always @(posedge clk_i) begin : result_sink
    int unsigned stall;
    score_t      exp_s;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_scores.size() == 0) begin
        $error("unexpected result: status %0d, probability %0h", m_axis_tuser,
               m_axis_tdata);
        error_count++;
      end else begin
        exp_s = pending_scores.pop_front();
        if (m_axis_tuser !== exp_s.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_s.status, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata !== exp_s.probability) begin
          $error("probability mismatch: expected %0h, actual %0h", exp_s.probability,
                 m_axis_tdata);
          error_count++;
        end
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      m_axis_tready <= (stall == 0);
      sink_hold     <= stall;
    end else if (sink_hold > 1) begin
      sink_hold <= sink_hold - 1;
    end else begin
      sink_hold     <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_saturation();
    test_extremes_and_shrink();
    test_zero_smoothing();
    test_register_limits();
    test_random_traffic();
    wait_results();
    repeat (64) @(posedge clk_i);
    if (error_count == 0 && pending_scores.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/lnbs_pkg.sv
rtl/core/lnbs_datapath.sv
rtl/core/lnbs_ctrl.sv
rtl/core/laplace_naive_bayes_score.sv
test/tb_laplace_naive_bayes_score.sv
